// ----- hw/rtl/sfsr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfsr_pkg
// Shared constants and types for the sync frame status receiver: frame
// layout codes, result kinds and the records passed between the parts.
// ----------------------------------------------------------------------------
package sfsr_pkg;

  // Longest frame accepted, in bytes, header and checksum included.
  localparam int FRAME_MAX = 64;

  // Byte index counter and frame total widths.
  localparam int CNT_W = $clog2(FRAME_MAX);
  localparam int TOT_W = 9;

  // Sync bytes and commands.
  localparam logic [7:0] SYNC_FIRST    = 8'h55;
  localparam logic [7:0] SYNC_SECOND   = 8'hAA;
  localparam logic [7:0] CMD_HEARTBEAT = 8'h00;
  localparam logic [7:0] CMD_STATUS    = 8'h07;

  // Frame layout.
  localparam logic [TOT_W-1:0] HDR_BYTES        = TOT_W'(7);
  localparam logic [TOT_W-1:0] STATUS_MIN_TOTAL = TOT_W'(12);
  localparam logic [CNT_W-1:0] IDX_CMD          = CNT_W'(3);
  localparam logic [CNT_W-1:0] IDX_LEN          = CNT_W'(5);
  localparam logic [CNT_W-1:0] IDX_DP           = CNT_W'(6);
  localparam logic [CNT_W-1:0] IDX_VAL_FIRST    = CNT_W'(10);
  localparam logic [CNT_W-1:0] IDX_VAL_LAST     = CNT_W'(13);

  // Data point numbers.
  localparam logic [7:0] DP_POWER   = 8'h01;
  localparam logic [7:0] DP_TARGET  = 8'h02;
  localparam logic [7:0] DP_CURRENT = 8'h03;
  localparam logic [7:0] DP_MODE    = 8'h04;
  localparam logic [7:0] DP_FAN     = 8'h05;
  localparam logic [7:0] DP_FAULT   = 8'h06;

  // Result kinds.
  localparam logic [2:0] KIND_HEARTBEAT = 3'd0;
  localparam logic [2:0] KIND_KNOWN     = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd2;
  localparam logic [2:0] KIND_OTHER     = 3'd3;
  localparam logic [2:0] KIND_BAD_SUM   = 3'd4;
  localparam logic [2:0] KIND_OVERLONG  = 3'd5;

  // Frame event from the parser to the update stage.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  dp;
    logic [7:0]  last_byte;
    logic [31:0] word;
  } event_t;

  // One complete result record.
  typedef struct packed {
    logic [2:0]         frame_kind;
    logic [7:0]         dp_id;
    logic [7:0]         power_state;
    logic signed [31:0] target_temp;
    logic signed [31:0] current_temp;
    logic [7:0]         mode_code;
    logic [7:0]         fan_code;
    logic [7:0]         fault_code;
    logic               online_flag;
    logic               changed_flag;
  } result_t;

endpackage

// ----- hw/rtl/sfsr_front.sv -----
// ----------------------------------------------------------------------------
// sfsr_front
// Byte parser: hunts for sync, tracks position, length, command, data point,
// value word and running sum, and classifies each finished or dropped frame.
// ----------------------------------------------------------------------------
module sfsr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          byte_in,
  output logic                ev_vld,
  output sfsr_pkg::event_t    ev
);

  logic [sfsr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [7:0]                 cmd_r, cmd_nxt;
  logic [7:0]                 dp_r, dp_nxt;
  logic [31:0]                val_r, val_nxt;
  logic [7:0]                 prev_r, prev_nxt;
  logic                       ev_vld_r, ev_vld_nxt;
  sfsr_pkg::event_t           ev_r, ev_nxt;

  logic [7:0]                 len_eff;
  logic [sfsr_pkg::TOT_W-1:0] total;
  logic [sfsr_pkg::TOT_W-1:0] idx_ext;
  logic                       past_len;
  logic                       overlong;
  logic                       final_byte;
  logic                       dp_known;
  logic [1:0]                 val_sel;

  // Frame total as seen on this beat (length taken on byte five).
  assign len_eff    = (cnt_r == sfsr_pkg::IDX_LEN) ? byte_in : len_r;
  assign total      = sfsr_pkg::HDR_BYTES + {1'b0, len_eff};
  assign idx_ext    = sfsr_pkg::TOT_W'(cnt_r);
  assign past_len   = (cnt_r >= sfsr_pkg::IDX_LEN);
  assign overlong   = past_len && (total > sfsr_pkg::TOT_W'(sfsr_pkg::FRAME_MAX));
  assign final_byte = past_len && ((idx_ext + sfsr_pkg::TOT_W'(1)) == total);
  assign dp_known   = (dp_r >= sfsr_pkg::DP_POWER) && (dp_r <= sfsr_pkg::DP_FAULT);
  assign val_sel    = 2'(cnt_r - sfsr_pkg::IDX_VAL_FIRST);

  // Next state of the parser for one accepted beat.
  always_comb begin
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    cmd_nxt    = cmd_r;
    dp_nxt     = dp_r;
    val_nxt    = val_r;
    prev_nxt   = prev_r;
    ev_vld_nxt = 1'b0;
    ev_nxt     = ev_r;
    if (byte_vld) begin
      prev_nxt = byte_in;
      if (cnt_r == '0) begin
        if (byte_in == sfsr_pkg::SYNC_FIRST) begin
          cnt_nxt = sfsr_pkg::CNT_W'(1);
          sum_nxt = sfsr_pkg::SYNC_FIRST;
          len_nxt = '0;
          cmd_nxt = '0;
          dp_nxt  = '0;
          val_nxt = '0;
        end
      end else if (cnt_r == sfsr_pkg::CNT_W'(1)) begin
        if (byte_in == sfsr_pkg::SYNC_SECOND) begin
          cnt_nxt = sfsr_pkg::CNT_W'(2);
          sum_nxt = sum_r + byte_in;
        end else if (byte_in != sfsr_pkg::SYNC_FIRST) begin
          cnt_nxt = '0;
        end
      end else begin
        if (cnt_r == sfsr_pkg::IDX_CMD) begin
          cmd_nxt = byte_in;
        end
        len_nxt = len_eff;
        ev_nxt.last_byte = prev_r;
        ev_nxt.word      = val_r;
        if (overlong) begin
          cnt_nxt    = '0;
          ev_vld_nxt = 1'b1;
          ev_nxt.kind = sfsr_pkg::KIND_OVERLONG;
          ev_nxt.dp   = '0;
        end else if (final_byte) begin
          cnt_nxt    = '0;
          ev_vld_nxt = 1'b1;
          ev_nxt.dp  = '0;
          if (byte_in != sum_r) begin
            ev_nxt.kind = sfsr_pkg::KIND_BAD_SUM;
          end else if (cmd_r == sfsr_pkg::CMD_HEARTBEAT) begin
            ev_nxt.kind = sfsr_pkg::KIND_HEARTBEAT;
          end else if (cmd_r == sfsr_pkg::CMD_STATUS) begin
            if (total < sfsr_pkg::STATUS_MIN_TOTAL) begin
              ev_nxt.kind = sfsr_pkg::KIND_UNKNOWN;
            end else begin
              ev_nxt.dp   = dp_r;
              ev_nxt.kind = dp_known ? sfsr_pkg::KIND_KNOWN : sfsr_pkg::KIND_UNKNOWN;
            end
          end else begin
            ev_nxt.kind = sfsr_pkg::KIND_OTHER;
          end
        end else begin
          if (cnt_r == sfsr_pkg::IDX_DP) begin
            dp_nxt = byte_in;
          end
          // Value bytes ten to thirteen fill the word most significant first.
          if ((cnt_r >= sfsr_pkg::IDX_VAL_FIRST) && (cnt_r <= sfsr_pkg::IDX_VAL_LAST)) begin
            case (val_sel)
              2'd0:    val_nxt[31:24] = byte_in;
              2'd1:    val_nxt[23:16] = byte_in;
              2'd2:    val_nxt[15:8]  = byte_in;
              default: val_nxt[7:0]   = byte_in;
            endcase
          end
          sum_nxt = sum_r + byte_in;
          cnt_nxt = cnt_r + sfsr_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sum_r    <= '0;
      len_r    <= '0;
      cmd_r    <= '0;
      dp_r     <= '0;
      val_r    <= '0;
      prev_r   <= '0;
      ev_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      len_r    <= len_nxt;
      cmd_r    <= cmd_nxt;
      dp_r     <= dp_nxt;
      val_r    <= val_nxt;
      prev_r   <= prev_nxt;
      ev_vld_r <= ev_vld_nxt;
    end
  end

  // Event payload.
  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

  assign ev_vld = ev_vld_r;
  assign ev     = ev_r;

endmodule

// ----- hw/rtl/sfsr_evq.sv -----
// ----------------------------------------------------------------------------
// sfsr_evq
// Two-entry queue of frame events between the parser and the update stage.
// ----------------------------------------------------------------------------
module sfsr_evq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sfsr_pkg::event_t wr_data,
  input  logic             rd_en,
  output sfsr_pkg::event_t rd_data,
  output logic             q_full,
  output logic             q_empty
);

  sfsr_pkg::event_t ent_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = ent_r[rd_ptr_r];

endmodule

// ----- hw/rtl/sfsr_back.sv -----
// ----------------------------------------------------------------------------
// sfsr_back
// Update stage: applies each frame event to the stored values and flags and
// queues the full result record for the output side.
// ----------------------------------------------------------------------------
module sfsr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ev_empty,
  input  sfsr_pkg::event_t  ev,
  output logic              ev_take,
  input  logic              res_pop,
  output logic              res_empty,
  output sfsr_pkg::result_t res
);

  logic [7:0]         power_r, power_nxt;
  logic signed [31:0] target_r, target_nxt;
  logic signed [31:0] current_r, current_nxt;
  logic [7:0]         mode_r, mode_nxt;
  logic [7:0]         fan_r, fan_nxt;
  logic [7:0]         fault_r, fault_nxt;
  logic               online_r, online_nxt;
  logic               changed_r, changed_nxt;

  sfsr_pkg::result_t  ent_r [2];
  sfsr_pkg::result_t  new_res;
  logic               wr_ptr_r, rd_ptr_r;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               do_rd;

  assign ev_take   = !ev_empty && (cnt_r != 2'd2);
  assign res_empty = (cnt_r == 2'd0);
  assign do_rd     = res_pop && !res_empty;

  // Stored value update for the event taken this cycle.
  always_comb begin
    power_nxt   = power_r;
    target_nxt  = target_r;
    current_nxt = current_r;
    mode_nxt    = mode_r;
    fan_nxt     = fan_r;
    fault_nxt   = fault_r;
    online_nxt  = online_r;
    changed_nxt = changed_r;
    if (ev_take) begin
      if (ev.kind == sfsr_pkg::KIND_HEARTBEAT) begin
        online_nxt = 1'b1;
      end
      if (ev.kind == sfsr_pkg::KIND_KNOWN) begin
        changed_nxt = 1'b1;
        unique case (ev.dp)
          sfsr_pkg::DP_POWER:   power_nxt   = ev.last_byte;
          sfsr_pkg::DP_TARGET:  target_nxt  = ev.word;
          sfsr_pkg::DP_CURRENT: current_nxt = ev.word;
          sfsr_pkg::DP_MODE:    mode_nxt    = ev.last_byte;
          sfsr_pkg::DP_FAN:     fan_nxt     = ev.last_byte;
          sfsr_pkg::DP_FAULT:   fault_nxt   = ev.last_byte;
          default:              changed_nxt = changed_r;
        endcase
      end
    end
  end

  // Result record carries the values after this frame's update.
  always_comb begin
    new_res.frame_kind   = ev.kind;
    new_res.dp_id        = ev.dp;
    new_res.power_state  = power_nxt;
    new_res.target_temp  = target_nxt;
    new_res.current_temp = current_nxt;
    new_res.mode_code    = mode_nxt;
    new_res.fan_code     = fan_nxt;
    new_res.fault_code   = fault_nxt;
    new_res.online_flag  = online_nxt;
    new_res.changed_flag = changed_nxt;
    cnt_nxt              = cnt_r + 2'(ev_take) - 2'(do_rd);
  end

  // Stored values, flags and result queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r   <= '0;
      target_r  <= '0;
      current_r <= '0;
      mode_r    <= '0;
      fan_r     <= '0;
      fault_r   <= '0;
      online_r  <= 1'b0;
      changed_r <= 1'b0;
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      power_r   <= power_nxt;
      target_r  <= target_nxt;
      current_r <= current_nxt;
      mode_r    <= mode_nxt;
      fan_r     <= fan_nxt;
      fault_r   <= fault_nxt;
      online_r  <= online_nxt;
      changed_r <= changed_nxt;
      wr_ptr_r  <= wr_ptr_r ^ ev_take;
      rd_ptr_r  <= rd_ptr_r ^ do_rd;
      cnt_r     <= cnt_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (ev_take) begin
      ent_r[wr_ptr_r] <= new_res;
    end
  end

  assign res = ent_r[rd_ptr_r];

endmodule

// ----- hw/rtl/sync_frame_status_receiver.sv -----
// ----------------------------------------------------------------------------
// sync_frame_status_receiver
// Serial frame receiver for a status-reporting climate unit: parses sync,
// length, command and first data point, checks the checksum, keeps the
// stored values and gives one result record per finished or dropped frame.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+--------------------------------------
//   input    | push / full         | in_rx_byte
//   result   | pop / empty         | out_frame_kind ... out_changed_flag
//
// One byte is taken per cycle while full is low; the parser keeps its whole
// frame context in registers, so back-to-back beats never stall it. Results
// pass the event register, event queue and result queue. full rises only
// when the two-entry event queue is occupied, which needs the result side to
// hold pop low over several frames. Reset is synchronous and clears all
// stored values and flags; the receiver restarts hunting for sync.
//
module sync_frame_status_receiver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_frame_kind,
  output logic [7:0]         out_dp_id,
  output logic [7:0]         out_power_state,
  output logic signed [31:0] out_target_temp,
  output logic signed [31:0] out_current_temp,
  output logic [7:0]         out_mode_code,
  output logic [7:0]         out_fan_code,
  output logic [7:0]         out_fault_code,
  output logic               out_online_flag,
  output logic               out_changed_flag
);

  logic              in_beat;
  logic              ev_vld;
  sfsr_pkg::event_t  ev_in;
  sfsr_pkg::event_t  ev_out;
  logic              ev_full;
  logic              ev_empty;
  logic              ev_take;
  sfsr_pkg::result_t res;

  assign in_beat = push && !full;
  assign full    = ev_full;

  // Front: byte parser and classifier.
  sfsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_beat),
    .byte_in  (in_rx_byte),
    .ev_vld   (ev_vld),
    .ev       (ev_in)
  );

  // Event queue between parser and update stage.
  sfsr_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_vld),
    .wr_data (ev_in),
    .rd_en   (ev_take),
    .rd_data (ev_out),
    .q_full  (ev_full),
    .q_empty (ev_empty)
  );

  // Back: stored value update and result queue.
  sfsr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_empty  (ev_empty),
    .ev        (ev_out),
    .ev_take   (ev_take),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  // Result record onto the ports.
  assign out_frame_kind   = res.frame_kind;
  assign out_dp_id        = res.dp_id;
  assign out_power_state  = res.power_state;
  assign out_target_temp  = res.target_temp;
  assign out_current_temp = res.current_temp;
  assign out_mode_code    = res.mode_code;
  assign out_fan_code     = res.fan_code;
  assign out_fault_code   = res.fault_code;
  assign out_online_flag  = res.online_flag;
  assign out_changed_flag = res.changed_flag;

`ifndef SYNTHESIS
  // The parser never emits an event while the queue is full.
  a_no_ev_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ev_vld |-> !$past(ev_full))
    else $error("frame event written into a full queue");

  // The online flag is sticky across successive results.
  a_online_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_online_flag) |=> (empty || out_online_flag))
    else $error("online flag dropped between results");

  // A data point number is only reported for status frames.
  a_dp_only_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_dp_id != 8'h00)) |->
      ((out_frame_kind == sfsr_pkg::KIND_KNOWN) ||
       (out_frame_kind == sfsr_pkg::KIND_UNKNOWN)))
    else $error("data point reported on a non-status result");
`endif

endmodule
